/* design/ssl_pkg.sv */
// ssl_pkg: request codes, sequencer state types and the compare result struct
// for the sorted sequential list. No dependencies.
`timescale 1ns / 1ps

package ssl_pkg;

  localparam int IDX_W = 7;
  localparam int VAL_W = 32;

  localparam logic [1:0] FN_ORD_INS = 2'd0;
  localparam logic [1:0] FN_POS_INS = 2'd1;
  localparam logic [1:0] FN_DELETE  = 2'd2;
  localparam logic [1:0] FN_FIND    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_TAIL
  } state_t;

  // what the walk does with each entry that comes back from the ram
  typedef enum logic [1:0] {
    MD_SCAN_ORD,
    MD_SCAN_FIND,
    MD_SHIFT,
    MD_DELETE
  } mode_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

/* design/ssl_ram.sv */
// ssl_ram: generic simple dual-port ram, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ssl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ssl_cmp.sv */
// ssl_cmp: shared signed compare unit, used by both search and ordered insert.
// Depends on ssl_pkg.
`timescale 1ns / 1ps

module ssl_cmp (
  input  logic signed [ssl_pkg::VAL_W-1:0] key,
  input  logic signed [ssl_pkg::VAL_W-1:0] entry,
  output ssl_pkg::cmp_res_t                res
);

  import ssl_pkg::*;

  always_comb begin
    res.lt = key < entry;
    res.eq = key == entry;
  end

endmodule

/* design/sorted_sequential_list.sv */
// sorted_sequential_list: top level, request sequencer and entry storage.
// Depends on ssl_pkg, ssl_ram and ssl_cmp.
//
// Usage: a request (in_func, in_position, in_value) transfers on a rising edge
// with start high and busy low. Every request gives exactly one result: a
// one-cycle out_valid strobe with out_ok, out_index and out_count. The receiver
// cannot stall, so results must be taken in the strobe cycle.
// Entries live in a ram with one write and one registered read port; the
// sequencer walks them one entry per cycle through a single compare unit.
// Ordered insert scans for the first larger entry, then ripple-shifts the rest
// up one slot; positional insert ripples from the position; delete moves the
// later entries down one slot; find scans until a match or the last entry.
// A rejected request, an insert into an empty list or at the end, and a delete
// of the last entry skip the walk. busy stays high until the strobe cycle; a
// request walks the entries through the single ram read port.
// Reset empties the list at once; no clearing pass is needed since only
// entries below the count are ever read.
`timescale 1ns / 1ps

module sorted_sequential_list #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_func,
  input  logic [ssl_pkg::IDX_W-1:0]        in_position,
  input  logic signed [ssl_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  output logic                             out_ok,
  output logic [ssl_pkg::IDX_W-1:0]        out_index,
  output logic [ssl_pkg::IDX_W-1:0]        out_count
);

  import ssl_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > IDX_W) ? CW : IDX_W;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  logic [CW-1:0]           rd_i_r, rd_i_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]           rd_addr_r, rd_addr_nxt;
  logic signed [VAL_W-1:0] carry_r, carry_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]           hit_r, hit_nxt;
  logic [CW-1:0]           used_r, used_nxt;

  logic                    out_valid_r, out_ok_r;
  logic [IDX_W-1:0]        out_index_r, out_count_r;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic signed [VAL_W-1:0] ram_wdata, ram_rdata;

  cmp_res_t                cmp;

  logic                    finish, fin_ok;
  logic [CW-1:0]           fin_idx;
  logic                    full, last;
  logic [WW-1:0]           pos_ext, used_ext;

  ssl_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ssl_cmp u_cmp (
    .key  (val_r),
    .entry(ram_rdata),
    .res  (cmp)
  );

  assign full     = used_r == CW'(CAPACITY);
  assign pos_ext  = WW'(in_position);
  assign used_ext = WW'(used_r);
  assign last     = CW'(rd_addr_r) == used_r - CW'(1);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    rd_i_nxt    = rd_i_r;
    rd_vld_nxt  = 1'b0;
    rd_addr_nxt = rd_addr_r;
    carry_nxt   = carry_r;
    val_nxt     = val_r;
    hit_nxt     = hit_r;
    used_nxt    = used_r;
    ram_re      = 1'b0;
    ram_raddr   = rd_i_r[AW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = rd_addr_r;
    ram_wdata   = carry_r;
    finish      = 1'b0;
    fin_ok      = 1'b0;
    fin_idx     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt   = in_value;
          carry_nxt = in_value;
          case (in_func)
            FN_ORD_INS: begin
              if (full) begin
                finish = 1'b1;
              end else if (used_r == '0) begin
                hit_nxt   = '0;
                state_nxt = ST_TAIL;
              end else begin
                mode_nxt  = MD_SCAN_ORD;
                rd_i_nxt  = '0;
                state_nxt = ST_WALK;
              end
            end
            FN_POS_INS: begin
              if (full || pos_ext > used_ext) begin
                finish = 1'b1;
              end else if (pos_ext == used_ext) begin
                hit_nxt   = CW'(in_position);
                state_nxt = ST_TAIL;
              end else begin
                // ripple from the position: each old entry moves up one slot
                hit_nxt   = CW'(in_position);
                rd_i_nxt  = CW'(in_position);
                mode_nxt  = MD_SHIFT;
                state_nxt = ST_WALK;
              end
            end
            FN_DELETE: begin
              if (pos_ext >= used_ext) begin
                finish = 1'b1;
              end else if (pos_ext == used_ext - WW'(1)) begin
                // last entry: nothing to move
                finish   = 1'b1;
                fin_ok   = 1'b1;
                fin_idx  = CW'(in_position);
                used_nxt = used_r - CW'(1);
              end else begin
                hit_nxt   = CW'(in_position);
                rd_i_nxt  = CW'(in_position) + CW'(1);
                mode_nxt  = MD_DELETE;
                state_nxt = ST_WALK;
              end
            end
            default: begin
              if (used_r == '0) begin
                finish = 1'b1;
              end else begin
                mode_nxt  = MD_SCAN_FIND;
                rd_i_nxt  = '0;
                state_nxt = ST_WALK;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        if (rd_i_r < used_r) begin
          ram_re      = 1'b1;
          rd_i_nxt    = rd_i_r + CW'(1);
          rd_vld_nxt  = 1'b1;
          rd_addr_nxt = rd_i_r[AW-1:0];
        end
        if (rd_vld_r) begin
          case (mode_r)
            MD_SCAN_FIND: begin
              if (cmp.eq) begin
                finish    = 1'b1;
                fin_ok    = 1'b1;
                fin_idx   = CW'(rd_addr_r);
                state_nxt = ST_IDLE;
              end else if (last) begin
                finish    = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
            MD_SCAN_ORD: begin
              if (cmp.lt) begin
                // first larger entry: drop the value here and start the ripple
                ram_we    = 1'b1;
                ram_wdata = val_r;
                carry_nxt = ram_rdata;
                hit_nxt   = CW'(rd_addr_r);
                mode_nxt  = MD_SHIFT;
                if (last) begin
                  state_nxt = ST_TAIL;
                end
              end else if (last) begin
                carry_nxt = val_r;
                hit_nxt   = used_r;
                state_nxt = ST_TAIL;
              end
            end
            MD_SHIFT: begin
              ram_we    = 1'b1;
              ram_wdata = carry_r;
              carry_nxt = ram_rdata;
              if (last) begin
                state_nxt = ST_TAIL;
              end
            end
            default: begin
              ram_we    = 1'b1;
              ram_waddr = rd_addr_r - AW'(1);
              ram_wdata = ram_rdata;
              if (last) begin
                finish    = 1'b1;
                fin_ok    = 1'b1;
                fin_idx   = hit_r;
                used_nxt  = used_r - CW'(1);
                state_nxt = ST_IDLE;
              end
            end
          endcase
        end
        if (state_nxt != ST_WALK) begin
          rd_vld_nxt = 1'b0;
        end
      end
      ST_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = used_r[AW-1:0];
        ram_wdata = carry_r;
        used_nxt  = used_r + CW'(1);
        finish    = 1'b1;
        fin_ok    = 1'b1;
        fin_idx   = hit_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MD_SCAN_ORD;
      rd_vld_r    <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      rd_vld_r    <= rd_vld_nxt;
      used_r      <= used_nxt;
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    rd_i_r    <= rd_i_nxt;
    rd_addr_r <= rd_addr_nxt;
    carry_r   <= carry_nxt;
    val_r     <= val_nxt;
    hit_r     <= hit_nxt;
    if (finish) begin
      out_ok_r    <= fin_ok;
      out_index_r <= IDX_W'(fin_idx);
      out_count_r <= IDX_W'(used_nxt);
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_index = out_index_r;
  assign out_count = out_count_r;

  // list never grows past its capacity
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // each accepted request either keeps the block busy or answers at once
  a_start_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("request transfer lost");

  // the result strobe comes with the sequencer back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_IDLE)
    else $error("result strobe while still busy");

  // the ram is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !ram_we)
    else $error("ram write while idle");

  // the count only moves together with a result
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    used_r != $past(used_r) |-> out_valid)
    else $error("count changed without a result");

endmodule
